// ----- design/morse_encoder_decoder_macros.svh -----
// ============================================================================
// Assertion macros for the Morse codec
// Shared concurrent assertion forms, clocked on aclk and idle during reset.
// ============================================================================
`ifndef MORSE_ENCODER_DECODER_MACROS_SVH
`define MORSE_ENCODER_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MCODEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define MCODEC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MCODEC_ASSERT(lbl, prop, msg)
`define MCODEC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- design/mcodec_pkg.sv -----
// ============================================================================
// Morse codec package
// Widths, character codes, the job descriptor and the Morse code tables.
// ============================================================================
package mcodec_pkg;

    localparam int MAX_ELEMENTS = 5;
    localparam int ELEM_W       = MAX_ELEMENTS;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 2);
    localparam int NUM_SYMBOLS  = 36;

    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    localparam logic [7:0] SYM_CHARS [NUM_SYMBOLS] = '{
        "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
        "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
        "1", "2", "3", "4", "5", "6", "7", "8", "9", "0"
    };

    // Elements are right aligned, first element most significant, dash = 1.
    typedef struct packed {
        logic [CNT_W-1:0]  len;
        logic [ELEM_W-1:0] bits;
    } code_t;

    // One unit of output work. Emission order: elements (left aligned),
    // decoded character, space, newline.
    typedef struct packed {
        logic [CNT_W-1:0]  elem_count;
        logic [ELEM_W-1:0] elem_bits;
        logic              has_char;
        logic [7:0]        char_byte;
        logic              has_space;
        logic              has_nl;
    } job_t;

    function automatic code_t mk_code(input int n, input logic [4:0] b);
        code_t r;
        r.len  = CNT_W'(n);
        r.bits = ELEM_W'(b);
        return r;
    endfunction

    function automatic code_t enc_lookup(input logic [7:0] c);
        code_t r;
        r = '0;
        unique case (c)
            "a": r = mk_code(2, 5'b00001);
            "b": r = mk_code(4, 5'b01000);
            "c": r = mk_code(4, 5'b01010);
            "d": r = mk_code(3, 5'b00100);
            "e": r = mk_code(1, 5'b00000);
            "f": r = mk_code(4, 5'b00010);
            "g": r = mk_code(3, 5'b00110);
            "h": r = mk_code(4, 5'b00000);
            "i": r = mk_code(2, 5'b00000);
            "j": r = mk_code(4, 5'b00111);
            "k": r = mk_code(3, 5'b00101);
            "l": r = mk_code(4, 5'b00100);
            "m": r = mk_code(2, 5'b00011);
            "n": r = mk_code(2, 5'b00010);
            "o": r = mk_code(3, 5'b00111);
            "p": r = mk_code(4, 5'b00110);
            "q": r = mk_code(4, 5'b01101);
            "r": r = mk_code(3, 5'b00010);
            "s": r = mk_code(3, 5'b00000);
            "t": r = mk_code(1, 5'b00001);
            "u": r = mk_code(3, 5'b00001);
            "v": r = mk_code(4, 5'b00001);
            "w": r = mk_code(3, 5'b00011);
            "x": r = mk_code(4, 5'b01001);
            "y": r = mk_code(4, 5'b01011);
            "z": r = mk_code(4, 5'b01100);
            "1": r = mk_code(5, 5'b01111);
            "2": r = mk_code(5, 5'b00111);
            "3": r = mk_code(5, 5'b00011);
            "4": r = mk_code(5, 5'b00001);
            "5": r = mk_code(5, 5'b00000);
            "6": r = mk_code(5, 5'b10000);
            "7": r = mk_code(5, 5'b11000);
            "8": r = mk_code(5, 5'b11100);
            "9": r = mk_code(5, 5'b11110);
            "0": r = mk_code(5, 5'b11111);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dec_lookup(input logic [CNT_W-1:0] len,
                                              input logic [ELEM_W-1:0] bits);
        logic [7:0] r;
        code_t      k;
        r = CHAR_NONE;
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            k = enc_lookup(SYM_CHARS[i]);
            if (k.len == len && k.bits == bits) begin
                r = SYM_CHARS[i];
            end
        end
        return r;
    endfunction

endpackage

// ----- design/mcodec_front.sv -----
// ============================================================================
// Morse codec front end
// Accepts input bytes, holds the mode and the element buffer, and turns each
// byte that yields output into an output job for the back end.
// ============================================================================
`include "morse_encoder_decoder_macros.svh"

module mcodec_front
    import mcodec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       q_ready,
    output logic       q_push,
    output job_t       q_job
);

    logic              mode_reg;
    logic [ELEM_W-1:0] elem_bits_reg, elem_bits_next;
    logic [CNT_W-1:0]  elem_cnt_reg, elem_cnt_next;
    logic              accept;
    logic              emits;
    logic [7:0]        c_low;
    code_t             code;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept && emits;

    always_comb begin
        c_low = s_char_in;
        if (s_char_in >= CHAR_UP_A && s_char_in <= CHAR_UP_Z) begin
            c_low = s_char_in + CASE_DIFF;
        end
        code           = enc_lookup(c_low);
        q_job          = '0;
        emits          = 1'b0;
        elem_bits_next = elem_bits_reg;
        elem_cnt_next  = elem_cnt_reg;
        if (!mode_reg) begin
            if (c_low == CHAR_DOT || c_low == CHAR_NL) begin
                q_job.has_nl = 1'b1;
                emits        = 1'b1;
            end else if (c_low != CHAR_SPACE) begin
                q_job.elem_count = code.len;
                q_job.elem_bits  = ELEM_W'(code.bits << (CNT_W'(ELEM_W) - code.len));
                q_job.has_space  = 1'b1;
                emits            = 1'b1;
            end
        end else begin
            if (s_char_in == CHAR_DOT || s_char_in == CHAR_DASH) begin
                if (elem_cnt_reg < CNT_W'(MAX_ELEMENTS)) begin
                    elem_bits_next = {elem_bits_reg[ELEM_W-2:0], s_char_in == CHAR_DASH};
                    elem_cnt_next  = elem_cnt_reg + CNT_W'(1);
                end else begin
                    elem_cnt_next = CNT_W'(MAX_ELEMENTS + 1);
                end
            end else begin
                if (elem_cnt_reg != '0) begin
                    q_job.has_char  = 1'b1;
                    q_job.has_space = 1'b1;
                    q_job.char_byte = (elem_cnt_reg > CNT_W'(MAX_ELEMENTS)) ? CHAR_NONE
                                    : dec_lookup(elem_cnt_reg, elem_bits_reg);
                end
                q_job.has_nl   = (s_char_in == CHAR_NL);
                emits          = q_job.has_char || q_job.has_nl;
                elem_bits_next = '0;
                elem_cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            elem_bits_reg <= '0;
            elem_cnt_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_mode;
            end
            if (accept) begin
                elem_bits_reg <= elem_bits_next;
                elem_cnt_reg  <= elem_cnt_next;
            end
        end
    end

    `MCODEC_ASSERT(a_cnt_range, elem_cnt_reg <= CNT_W'(MAX_ELEMENTS + 1), "element count overflow")

endmodule

// ----- design/mcodec_queue.sv -----
// ============================================================================
// Morse codec job queue
// Two-entry queue of jobs between the front end and the back end.
// ============================================================================
`include "morse_encoder_decoder_macros.svh"

module mcodec_queue
    import mcodec_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    output logic in_ready,
    input  job_t push_job,
    input  logic pop,
    output logic out_valid,
    output job_t out_job
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    `MCODEC_ASSERT(a_q_count, count_reg <= 2'd2, "queue count out of range")
    `MCODEC_ASSERT_IMPL(a_q_push, push, count_reg != 2'd2, "push into full queue")
    `MCODEC_ASSERT_IMPL(a_q_pop, pop, count_reg != 2'd0, "pop from empty queue")

endmodule

// ----- design/mcodec_back.sv -----
// ============================================================================
// Morse codec back end
// Takes jobs from the queue and emits one output byte per cycle into the
// output register while the receiver does not hold m_ready low.
// ============================================================================
`include "morse_encoder_decoder_macros.svh"

module mcodec_back
    import mcodec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last
);

    job_t       job_reg, job_next;
    job_t       rest;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_char_reg;
    logic       m_last_reg;
    logic [7:0] byte_out;
    logic       active;
    logic       last;
    logic       emit;
    logic       load;

    assign active = (job_reg.elem_count != '0) || job_reg.has_char
                 || job_reg.has_space || job_reg.has_nl;
    assign emit   = active && (!m_valid_reg || m_ready);
    assign load   = q_valid && (!active || (emit && last));
    assign q_pop  = load;

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last     = m_last_reg;

    always_comb begin
        rest = job_reg;
        if (job_reg.elem_count != '0) begin
            byte_out        = job_reg.elem_bits[ELEM_W-1] ? CHAR_DASH : CHAR_DOT;
            rest.elem_count = job_reg.elem_count - CNT_W'(1);
            rest.elem_bits  = {job_reg.elem_bits[ELEM_W-2:0], 1'b0};
        end else if (job_reg.has_char) begin
            byte_out      = job_reg.char_byte;
            rest.has_char = 1'b0;
        end else if (job_reg.has_space) begin
            byte_out       = CHAR_SPACE;
            rest.has_space = 1'b0;
        end else begin
            byte_out    = CHAR_NL;
            rest.has_nl = 1'b0;
        end
        last = (rest.elem_count == '0) && !rest.has_char && !rest.has_space && !rest.has_nl;

        job_next = job_reg;
        if (load) begin
            job_next = q_job;
        end else if (emit) begin
            job_next = rest;
        end

        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_out_char_reg <= byte_out;
            m_last_reg     <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            job_reg     <= job_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `MCODEC_ASSERT(a_job_len, job_reg.elem_count <= CNT_W'(MAX_ELEMENTS), "job too long")

endmodule

// ----- design/morse_encoder_decoder.sv -----
// ============================================================================
// Morse encoder and decoder
// ASCII to Morse and Morse to ASCII codec with a front end, a job queue and
// an output back end.
// ============================================================================
// Input bytes arrive on the s_ channel (s_valid, s_ready, s_char_in). Output
// bytes leave on the m_ channel (m_valid, m_ready, m_out_char, m_last), and
// m_last marks the final beat caused by one input byte. The mode register is
// written through cfg_valid, cfg_ready and cfg_mode: 0 encodes text to Morse,
// 1 decodes Morse to text. Write it only while the block is idle.
// An input byte produces zero to six output beats. Its job passes through the
// job queue and the back end's job register, and its first beat is then
// registered into the single output register. The back end emits one beat
// per cycle while the receiver does not hold m_ready low. Jobs follow each
// other without a gap, and the front end keeps accepting into a two-entry job
// queue while the back end is busy.
// Reset clears the mode to encode, empties the element buffer, the queue and
// the output register. When the receiver holds m_ready low, the output beat
// stays put, the queue fills, and s_ready falls once the queue is full.
// ============================================================================
`include "morse_encoder_decoder_macros.svh"

module morse_encoder_decoder
    import mcodec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last
);

    logic q_push;
    logic q_in_ready;
    job_t push_job;
    logic q_pop;
    logic q_valid;
    job_t q_job;

    mcodec_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_mode  (cfg_mode),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .q_ready   (q_in_ready),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    mcodec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_in_ready),
        .push_job  (push_job),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_job   (q_job)
    );

    mcodec_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

// ----- tb/morse_codec_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Morse codec checker
// Watches the configuration, input and output channels of the codec. It
// keeps its own copy of the mode and the element buffer, predicts the output
// beats of every accepted input byte, and compares each accepted output beat
// with the oldest predicted one.
// ============================================================================

module morse_codec_checker
    import mcodec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_mode,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_last,
    output int         mismatches,
    output int         beats_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } morse_beat_t;

    string              alphabet = "abcdefghijklmnopqrstuvwxyz1234567890";
    logic               mode_q;
    logic [ELEM_W-1:0]  elem_bits;
    logic [CNT_W-1:0]   elem_count;
    morse_beat_t        expected_beats [$];
    morse_beat_t        head_beat;

    function automatic string morse_pattern(input logic [7:0] c);
        case (c)
            "a": return ".-";
            "b": return "-...";
            "c": return "-.-.";
            "d": return "-..";
            "e": return ".";
            "f": return "..-.";
            "g": return "--.";
            "h": return "....";
            "i": return "..";
            "j": return ".---";
            "k": return "-.-";
            "l": return ".-..";
            "m": return "--";
            "n": return "-.";
            "o": return "---";
            "p": return ".--.";
            "q": return "--.-";
            "r": return ".-.";
            "s": return "...";
            "t": return "-";
            "u": return "..-";
            "v": return "...-";
            "w": return ".--";
            "x": return "-..-";
            "y": return "-.--";
            "z": return "--..";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            "0": return "-----";
            default: return "";
        endcase
    endfunction

    function automatic logic [7:0] decode_elements(input logic [CNT_W-1:0] count,
                                                   input logic [ELEM_W-1:0] bits);
        string             pat;
        logic [ELEM_W-1:0] pat_bits;
        logic [7:0]        found;
        found = CHAR_NONE;
        if (count <= MAX_ELEMENTS) begin
            for (int i = 0; i < alphabet.len(); i++) begin
                pat = morse_pattern(alphabet[i]);
                pat_bits = '0;
                for (int j = 0; j < pat.len(); j++) begin
                    pat_bits = {pat_bits[ELEM_W-2:0], pat[j] == CHAR_DASH};
                end
                if (pat.len() == count && pat_bits == bits) begin
                    found = alphabet[i];
                end
            end
        end
        return found;
    endfunction

    task automatic predict_response(input logic [7:0] c_in);
        logic [7:0]  c;
        logic [7:0]  beats [$];
        string       pat;
        morse_beat_t b;
        c = c_in;
        if (!mode_q) begin
            if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
                c = c + CASE_DIFF;
            end
            if (c == CHAR_DOT || c == CHAR_NL) begin
                beats.push_back(CHAR_NL);
            end else if (c != CHAR_SPACE) begin
                pat = morse_pattern(c);
                for (int j = 0; j < pat.len(); j++) begin
                    beats.push_back(pat[j]);
                end
                beats.push_back(CHAR_SPACE);
            end
        end else if (c == CHAR_DOT || c == CHAR_DASH) begin
            if (elem_count < MAX_ELEMENTS) begin
                elem_bits  = {elem_bits[ELEM_W-2:0], c == CHAR_DASH};
                elem_count = elem_count + 1'b1;
            end else begin
                elem_count = CNT_W'(MAX_ELEMENTS + 1);
            end
        end else begin
            if (elem_count != 0) begin
                beats.push_back(decode_elements(elem_count, elem_bits));
                beats.push_back(CHAR_SPACE);
            end
            elem_bits  = '0;
            elem_count = '0;
            if (c == CHAR_NL) begin
                beats.push_back(CHAR_NL);
            end
        end
        foreach (beats[k]) begin
            b.ch   = beats[k];
            b.last = (k == beats.size() - 1);
            expected_beats.push_back(b);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q     = 1'b0;
            elem_bits  = '0;
            elem_count = '0;
            expected_beats.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_q = cfg_mode;
            end
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected output beat: out_char %h, last %b",
                           m_out_char, m_last);
                    mismatches++;
                end else begin
                    head_beat = expected_beats.pop_front();
                    if (m_out_char !== head_beat.ch) begin
                        $error("out_char mismatch: expected %h, actual %h",
                               head_beat.ch, m_out_char);
                        mismatches++;
                    end
                    if (m_last !== head_beat.last) begin
                        $error("last mismatch: expected %b, actual %b",
                               head_beat.last, m_last);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_response(s_char_in);
            end
        end
        beats_pending = expected_beats.size();
    end

endmodule

// ----- tb/morse_encoder_decoder_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Morse codec testbench
// Drives text and Morse bytes into the codec in both modes, first a few
// directed cases and then random phases with and without idling on either
// side, including one long receiver hold-off. A checker beside the codec
// predicts and compares every output beat.
// ============================================================================

module morse_encoder_decoder_test
    import mcodec_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 49;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_mode  = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last;

    int    mismatches;
    int    beats_pending;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    hold_left      = 0;
    int    cycle_count    = 0;
    int    bytes_sent     = 0;
    string text_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    morse_encoder_decoder u_dut (.*);

    morse_codec_checker u_checker (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_char_in = c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_byte(txt[i]);
        end
    endtask

    task automatic write_mode(input logic m);
        s_valid = 1'b0;
        while (beats_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_mode  = m;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_text_byte();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) begin
            send_byte(text_chars[$urandom_range(text_chars.len() - 1)]);
        end else if (sel == 6) begin
            case ($urandom_range(2))
                0:       send_byte(CHAR_DOT);
                1:       send_byte(CHAR_SPACE);
                default: send_byte(CHAR_NL);
            endcase
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic send_random_morse_group();
        int n;
        int sel;
        n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        repeat (n) begin
            send_byte($urandom_range(1) ? CHAR_DASH : CHAR_DOT);
        end
        sel = $urandom_range(9);
        if (sel < 6) begin
            send_byte(CHAR_SPACE);
        end else if (sel < 8) begin
            send_byte(CHAR_NL);
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic m, input int idle_pct, input int stall_pct,
                             input int hold_cycles);
        int first;
        write_mode(m);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_left      = hold_cycles;
        first          = bytes_sent;
        while (bytes_sent - first < PHASE_BYTES) begin
            if (!m) begin
                send_random_text_byte();
            end else if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_random_morse_group();
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        write_mode(1'b0);
        send_text("Az09. \n!");
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);

        write_mode(1'b1);
        send_text(".- ......\n..--");
        send_byte(8'h80);
        send_byte(CHAR_NL);
        send_byte(CHAR_SPACE);

        run_phase(1'b0, 0, 0, 300);
        run_phase(1'b1, 0, 0, 0);
        run_phase(1'b0, 78, 0, 0);
        run_phase(1'b1, 78, 0, 0);
        run_phase(1'b0, 0, 78, 0);
        run_phase(1'b1, 0, 78, 0);
        run_phase(1'b0, 33, 33, 0);
        run_phase(1'b1, 33, 33, 0);

        s_valid = 1'b0;
        while (beats_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/mcodec_pkg.sv
design/mcodec_front.sv
design/mcodec_queue.sv
design/mcodec_back.sv
design/morse_encoder_decoder.sv
tb/morse_codec_checker.sv
tb/morse_encoder_decoder_test.sv
